FILE: rtl/jkse_pkg.sv
// Shared types and constants for the JSON key string extractor.
`timescale 1ns / 1ps

package jkse_pkg;

  // Key storage and value limits
  localparam int unsigned KeyBytes     = 16;
  localparam int unsigned KeyLenW      = 5;
  localparam int unsigned ValueLenW    = 8;
  localparam int unsigned BraceW       = 8;
  localparam logic [BraceW-1:0] BraceLevelMax = 8'd255;

  // Configuration register map
  localparam int unsigned CfgIdxW = 2;
  localparam logic [CfgIdxW-1:0] CFG_KEY_LOW  = 2'd0;
  localparam logic [CfgIdxW-1:0] CFG_KEY_HIGH = 2'd1;
  localparam logic [CfgIdxW-1:0] CFG_KEY_LEN  = 2'd2;
  localparam logic [CfgIdxW-1:0] CFG_MAX_LEN  = 2'd3;

  // Result status codes
  localparam logic [2:0] ST_BYTE       = 3'd0;
  localparam logic [2:0] ST_DONE       = 3'd1;
  localparam logic [2:0] ST_NOT_FOUND  = 3'd2;
  localparam logic [2:0] ST_NOT_STRING = 3'd3;
  localparam logic [2:0] ST_BAD_VALUE  = 3'd4;

  // Characters of interest
  localparam logic [7:0] CH_QUOTE  = 8'h22;
  localparam logic [7:0] CH_BSLASH = 8'h5C;
  localparam logic [7:0] CH_LBRACE = 8'h7B;
  localparam logic [7:0] CH_RBRACE = 8'h7D;
  localparam logic [7:0] CH_COLON  = 8'h3A;
  localparam logic [7:0] CH_SPACE  = 8'h20;
  localparam logic [7:0] CH_TAB    = 8'h09;
  localparam logic [7:0] CH_CR     = 8'h0D;
  localparam logic [7:0] CH_LF     = 8'h0A;
  localparam logic [7:0] CH_BS     = 8'h08;
  localparam logic [7:0] CH_FF     = 8'h0C;
  localparam logic [7:0] CH_N      = 8'h6E;
  localparam logic [7:0] CH_R      = 8'h72;
  localparam logic [7:0] CH_T      = 8'h74;
  localparam logic [7:0] CH_B      = 8'h62;
  localparam logic [7:0] CH_F      = 8'h66;

  // Settings seen by the parser
  typedef struct packed {
    logic [8*KeyBytes-1:0] key;     // first char in low byte
    logic [KeyLenW-1:0]    klen;    // clamped to KeyBytes
    logic [ValueLenW-1:0]  vlimit;
  } cfg_t;

  // One parser result
  typedef struct packed {
    logic       vld;
    logic [7:0] value_byte;
    logic [2:0] status;
  } res_t;

endpackage

FILE: rtl/jkse_cfg_regs.sv
// Configuration register file for the JSON key string extractor.
`timescale 1ns / 1ps

module jkse_cfg_regs import jkse_pkg::*; (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               wr_en_i,
  input  logic [CfgIdxW-1:0] wr_idx_i,
  input  logic [63:0]        wr_data_i,
  output cfg_t               cfg_o
);

  logic [63:0]          key_lo_q, key_hi_q;
  logic [KeyLenW-1:0]   klen_q;
  logic [ValueLenW-1:0] vlim_q;
  logic [KeyLenW-1:0]   klen_wr;

  // lengths above the key store act as a full key
  assign klen_wr = (wr_data_i[KeyLenW-1:0] > KeyLenW'(KeyBytes)) ?
                   KeyLenW'(KeyBytes) : wr_data_i[KeyLenW-1:0];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      key_lo_q <= '0;
      key_hi_q <= '0;
      klen_q   <= KeyLenW'(1);
      vlim_q   <= '1;
    end else if (wr_en_i) begin
      unique case (wr_idx_i)
        CFG_KEY_LOW:  key_lo_q <= wr_data_i;
        CFG_KEY_HIGH: key_hi_q <= wr_data_i;
        CFG_KEY_LEN:  klen_q   <= klen_wr;
        CFG_MAX_LEN:  vlim_q   <= wr_data_i[ValueLenW-1:0];
        default: ;
      endcase
    end
  end

  assign cfg_o.key    = {key_hi_q, key_lo_q};
  assign cfg_o.klen   = klen_q;
  assign cfg_o.vlimit = vlim_q;

endmodule

FILE: rtl/jkse_parser.sv
// Document state and per-byte key search / value decode logic.
`timescale 1ns / 1ps

module jkse_parser import jkse_pkg::*; (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       step_i,
  input  logic [7:0] byte_i,
  input  logic       last_i,
  input  cfg_t       cfg_i,
  output res_t       res_o
);

  typedef enum logic [2:0] {
    PH_SEARCH, PH_AFTER_KEY, PH_AFTER_COLON, PH_VALUE, PH_DONE
  } phase_e;

  typedef struct packed {
    phase_e               phase;
    logic                 in_str;
    logic                 esc;
    logic [BraceW-1:0]    brace;
    logic [KeyLenW-1:0]   kcnt;
    logic                 kmatch;
    logic [ValueLenW-1:0] vcnt;
  } doc_t;

  typedef struct packed {
    doc_t s;
    logic underflow;
  } srch_t;

  localparam doc_t DocReset = '{phase: PH_SEARCH, in_str: 1'b0, esc: 1'b0,
                                brace: '0, kcnt: '0, kmatch: 1'b0, vcnt: '0};

  function automatic logic is_space(logic [7:0] b);
    return (b == CH_SPACE) || (b == CH_TAB) || (b == CH_CR) || (b == CH_LF);
  endfunction

  function automatic logic [7:0] decode_esc(logic [7:0] b);
    logic [7:0] r;
    case (b)
      CH_N:    r = CH_LF;
      CH_R:    r = CH_CR;
      CH_T:    r = CH_TAB;
      CH_B:    r = CH_BS;
      CH_F:    r = CH_FF;
      default: r = b;
    endcase
    return r;
  endfunction

  // One byte of the key search with string, escape and brace tracking.
  function automatic srch_t search_f(doc_t s, logic [7:0] b, cfg_t c);
    srch_t      r;
    logic [7:0] kch;
    logic       hit;
    r.s         = s;
    r.underflow = 1'b0;
    hit         = 1'b0;
    kch         = c.key[{s.kcnt[3:0], 3'b000} +: 8];
    if (s.kmatch) begin
      if (s.kcnt >= c.klen) begin
        r.s.kmatch = 1'b0;
        if (b == CH_QUOTE) begin
          r.s.phase  = PH_AFTER_KEY;
          r.s.in_str = 1'b0;
          r.s.esc    = 1'b0;
          r.s.kcnt   = '0;
          hit        = 1'b1;
        end
      end else if (b == kch) begin
        r.s.kcnt = s.kcnt + KeyLenW'(1);
      end else begin
        r.s.kmatch = 1'b0;
      end
    end
    if (!hit) begin
      if (s.esc) begin
        r.s.esc = 1'b0;
      end else if (b == CH_BSLASH) begin
        r.s.esc = 1'b1;
      end else if (b == CH_QUOTE) begin
        // opening quote restarts the matcher
        if (!s.in_str) begin
          r.s.kmatch = 1'b1;
          r.s.kcnt   = '0;
        end
        r.s.in_str = !s.in_str;
      end else if (!s.in_str) begin
        if (b == CH_LBRACE) begin
          if (s.brace < BraceLevelMax) r.s.brace = s.brace + BraceW'(1);
        end else if (b == CH_RBRACE) begin
          if (s.brace == '0) begin
            r.s.phase   = PH_DONE;
            r.underflow = 1'b1;
          end else begin
            r.s.brace = s.brace - BraceW'(1);
          end
        end
      end
    end
    return r;
  endfunction

  doc_t       doc_q, doc_d, resume;
  srch_t      sr;
  logic       rv;
  logic [2:0] rst_code;
  logic [7:0] vb;

  always_comb begin
    doc_d    = doc_q;
    rv       = 1'b0;
    rst_code = ST_BYTE;
    vb       = '0;
    resume   = doc_q;
    resume.phase  = PH_SEARCH;
    resume.in_str = 1'b0;
    resume.esc    = 1'b0;
    resume.kmatch = 1'b0;
    sr = search_f((doc_q.phase == PH_AFTER_KEY) ? resume : doc_q, byte_i, cfg_i);

    unique case (doc_q.phase)
      PH_SEARCH: begin
        doc_d = sr.s;
        if (sr.underflow) begin
          rv       = 1'b1;
          rst_code = ST_NOT_FOUND;
        end
      end
      PH_AFTER_KEY: begin
        if (is_space(byte_i)) begin
          doc_d = doc_q;
        end else if (byte_i == CH_COLON) begin
          doc_d.phase = PH_AFTER_COLON;
        end else begin
          // key without colon: back to searching with this byte
          doc_d = sr.s;
          if (sr.underflow) begin
            rv       = 1'b1;
            rst_code = ST_NOT_FOUND;
          end
        end
      end
      PH_AFTER_COLON: begin
        if (!is_space(byte_i)) begin
          if (byte_i == CH_QUOTE) begin
            doc_d.phase = PH_VALUE;
            doc_d.vcnt  = '0;
            doc_d.esc   = 1'b0;
          end else begin
            doc_d.phase = PH_DONE;
            rv          = 1'b1;
            rst_code    = ST_NOT_STRING;
          end
        end
      end
      PH_VALUE: begin
        if (doc_q.vcnt >= cfg_i.vlimit) begin
          doc_d.phase = PH_DONE;
          rv          = 1'b1;
          rst_code    = ST_BAD_VALUE;
        end else if (doc_q.esc) begin
          doc_d.esc  = 1'b0;
          doc_d.vcnt = doc_q.vcnt + ValueLenW'(1);
          vb         = decode_esc(byte_i);
          rv         = 1'b1;
        end else if (byte_i == CH_BSLASH) begin
          doc_d.esc = 1'b1;
        end else if (byte_i == CH_QUOTE) begin
          doc_d.phase = PH_DONE;
          rv          = 1'b1;
          rst_code    = ST_DONE;
        end else begin
          doc_d.vcnt = doc_q.vcnt + ValueLenW'(1);
          vb         = byte_i;
          rv         = 1'b1;
        end
      end
      PH_DONE: ;
      default: ;
    endcase

    // end of document: report the outcome if still open, then restart
    if (last_i) begin
      unique case (doc_d.phase)
        PH_SEARCH, PH_AFTER_KEY: begin
          rv = 1'b1; rst_code = ST_NOT_FOUND;
        end
        PH_AFTER_COLON: begin
          rv = 1'b1; rst_code = ST_NOT_STRING;
        end
        PH_VALUE: begin
          rv = 1'b1; rst_code = ST_BAD_VALUE;
        end
        default: ;
      endcase
      doc_d = DocReset;
    end

    res_o.vld        = rv;
    res_o.status     = rst_code;
    res_o.value_byte = (rst_code == ST_BYTE) ? vb : 8'h00;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      doc_q <= DocReset;
    end else if (step_i) begin
      doc_q <= doc_d;
    end
  end

  // Key match state is dropped before the colon check
  a_after_key_clean: assert property (@(posedge clk_i) disable iff (!rst_ni)
    doc_q.phase == PH_AFTER_KEY |-> !doc_q.kmatch && !doc_q.in_str && !doc_q.esc)
    else $error("after-key state carries stale search state");

  // A document restarts after its last byte
  a_last_restart: assert property (@(posedge clk_i) disable iff (!rst_ni)
    step_i && last_i |=> doc_q.phase == PH_SEARCH && doc_q.brace == '0)
    else $error("document state not restarted after last byte");

  // Value bytes only come out while inside a value
  a_byte_in_value: assert property (@(posedge clk_i) disable iff (!rst_ni)
    res_o.vld && res_o.status == ST_BYTE |-> doc_q.phase == PH_VALUE)
    else $error("value byte outside a value");

  // A document emits nothing more once it is done
  a_done_quiet: assert property (@(posedge clk_i) disable iff (!rst_ni)
    doc_q.phase == PH_DONE && !last_i |-> !res_o.vld)
    else $error("result after the final result");

endmodule

FILE: rtl/json_key_string_extractor.sv
// Top level of the JSON key string extractor: input and result registers.
`timescale 1ns / 1ps

//  channel | direction | handshake                | payload
//  --------+-----------+--------------------------+-----------------------------------
//  in      | sink      | in_valid_i / in_stall_o  | data_byte_i, last_byte_i
//  out     | source    | out_valid_o / out_stall_i| value_byte_o, status_o, final_res_o
//  cfg     | sink      | cfg_valid_i / cfg_ready_o| cfg_index_i, cfg_data_i
//
// One byte per clock sustained while no result is held back by out_stall_i. Each
// request sits in the input register, is parsed combinationally, and its result
// (if any) lands in the output register, which drives out_valid_o.
// A full output register only holds back a byte that produces a result;
// bytes that produce nothing keep flowing while the result waits.
// Reset (rst_ni low) empties both registers, restores the configuration
// defaults and restarts document state; no clearing pass is needed.

module json_key_string_extractor import jkse_pkg::*; (
  input  logic               clk_i,
  input  logic               rst_ni,
  // byte stream
  input  logic               in_valid_i,
  output logic               in_stall_o,
  input  logic [7:0]         data_byte_i,
  input  logic               last_byte_i,
  // results
  output logic               out_valid_o,
  input  logic               out_stall_i,
  output logic [7:0]         value_byte_o,
  output logic [2:0]         status_o,
  output logic               final_res_o,
  // configuration writes
  input  logic               cfg_valid_i,
  output logic               cfg_ready_o,
  input  logic [CfgIdxW-1:0] cfg_index_i,
  input  logic [63:0]        cfg_data_i
);

  cfg_t       cfg;
  res_t       res;

  logic       s1_vld_q;
  logic [7:0] s1_byte_q;
  logic       s1_last_q;
  logic       in_take;
  logic       advance;

  logic       out_vld_q;
  logic [7:0] out_byte_q;
  logic [2:0] out_status_q;

  // Config is to be written only while idle, which the block does not enforce; ready just keeps it off a held request.
  assign cfg_ready_o = !s1_vld_q;

  jkse_cfg_regs u_cfg (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .wr_en_i   (cfg_valid_i && cfg_ready_o),
    .wr_idx_i  (cfg_index_i),
    .wr_data_i (cfg_data_i),
    .cfg_o     (cfg)
  );

  jkse_parser u_parser (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .step_i (advance),
    .byte_i (s1_byte_q),
    .last_i (s1_last_q),
    .cfg_i  (cfg),
    .res_o  (res)
  );

  // The held byte moves on unless it has a result and the output is blocked.
  assign advance    = s1_vld_q && (!res.vld || !out_vld_q || !out_stall_i);
  assign in_stall_o = s1_vld_q && !advance;
  assign in_take    = in_valid_i && !in_stall_o;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_vld_q <= 1'b0;
    end else if (in_take) begin
      s1_vld_q <= 1'b1;
    end else if (advance) begin
      s1_vld_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_take) begin
      s1_byte_q <= data_byte_i;
      s1_last_q <= last_byte_i;
    end
  end

  // Result register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_vld_q <= 1'b0;
    end else if (advance && res.vld) begin
      out_vld_q <= 1'b1;
    end else if (!out_stall_i) begin
      out_vld_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (advance && res.vld) begin
      out_byte_q   <= res.value_byte;
      out_status_q <= res.status;
    end
  end

  assign out_valid_o  = out_vld_q;
  assign value_byte_o = out_byte_q;
  assign status_o     = out_status_q;
  assign final_res_o  = (out_status_q != ST_BYTE);

  // A held byte never stalls while the output has room
  a_no_false_stall: assert property (@(posedge clk_i) disable iff (!rst_ni)
    s1_vld_q && !out_vld_q |-> !in_stall_o)
    else $error("input stalled with an empty output register");

  // A stalled result is not overwritten by a new one
  a_no_overwrite: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_vld_q && out_stall_i |-> !(advance && res.vld))
    else $error("pending result overwritten");

  // A stalled result stays valid and unchanged
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_vld_q && out_stall_i |=>
      out_vld_q && $stable(out_byte_q) && $stable(out_status_q))
    else $error("stalled result changed");

endmodule
